[hw/rtl/assert_macros.svh]
// assertion helpers for the port checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge outside reset
`define CHK_HOLDS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("port check failed");

// consequent must hold in the cycle after the antecedent
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("port check failed");

`endif

[hw/rtl/gaps_pkg.sv]
package gaps_pkg;

    localparam int MAX_COLS    = 64;
    localparam int MAX_ROWS    = 64;
    localparam int TILE_PIXELS = 32;

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int CELL_W = COL_W + ROW_W;
    localparam int CELLS  = MAX_COLS * MAX_ROWS;
    localparam int CNT_W  = CELL_W + 1;
    localparam int DIM_W  = 7;
    localparam int G_W    = 20;
    localparam int F_W    = G_W + 1;
    localparam int PIX_W  = 11;

    localparam int STEP_STRAIGHT = 100;
    localparam int STEP_DIAG     = 114;

    localparam logic [1:0] FLAG_OPEN   = 2'b01;
    localparam logic [1:0] FLAG_CLOSED = 2'b10;

    localparam logic REG_GRID_W = 1'b0;
    localparam logic REG_GRID_H = 1'b1;

    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_SEARCH = 2'd1,
        ACT_READ   = 2'd2,
        ACT_NOP    = 2'd3
    } t_action;

    typedef struct packed {
        t_action     action;
        logic [5:0]  tile_x;
        logic [5:0]  tile_y;
        logic [5:0]  goal_x;
        logic [5:0]  goal_y;
        logic        solid_bit;
        logic [11:0] path_index;
    } t_in_item;

    typedef struct packed {
        logic [12:0] path_length;
        logic [10:0] pixel_x;
        logic [10:0] pixel_y;
        logic        entry_valid;
    } t_out_item;

    // heap entry ordered by f, then by cell index
    typedef struct packed {
        logic [F_W-1:0]    f;
        logic [CELL_W-1:0] loc;
    } t_heap_ent;

endpackage

[hw/rtl/gaps_octile.sv]
module gaps_octile import gaps_pkg::*; (
    input  logic             i_clk,
    input  logic [COL_W-1:0] i_x,
    input  logic [ROW_W-1:0] i_y,
    input  logic [COL_W-1:0] i_gx,
    input  logic [ROW_W-1:0] i_gy,
    output logic [G_W-1:0]   o_dist
);

    logic [COL_W-1:0] dx;
    logic [ROW_W-1:0] dy;
    logic [G_W-1:0]   lo;
    logic [G_W-1:0]   hi;
    logic [G_W-1:0]   r_dist;

    assign dx = (i_x > i_gx) ? i_x - i_gx : i_gx - i_x;
    assign dy = (i_y > i_gy) ? i_y - i_gy : i_gy - i_y;
    assign lo = (G_W'(dx) < G_W'(dy)) ? G_W'(dx) : G_W'(dy);
    assign hi = (G_W'(dx) < G_W'(dy)) ? G_W'(dy) : G_W'(dx);

    always_ff @(posedge i_clk) begin
        r_dist <= G_W'(STEP_DIAG) * lo + G_W'(STEP_STRAIGHT) * (hi - lo);
    end

    assign o_dist = r_dist;

endmodule

[hw/rtl/grid_astar_path_search_top.sv]
// search: open/closed clear of every cell, then per expanded cell a pop (loop, top, last states),
// sift-down levels (left, right, compare), a check of each neighbor and sift-up levels; then a trace
// of the path back from the goal, one entry per step; write, read and no-op items: one item at a time
// every heap and cell table has its own memory with one write port and one registered read port
// reset (synchronous, active low) sweeps all 4096 cells of the solid map to clear,
// no item is taken meanwhile; config writes are taken at any time outside reset
module grid_astar_path_search_top import gaps_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [0:0]       i_cfg_index,
    input  logic [DIM_W-1:0] i_cfg_data
);

    typedef enum logic [24:0] {
        S_CLR_MAP  = 25'h0000001,
        S_IDLE     = 25'h0000002,
        S_RD_ISS   = 25'h0000004,
        S_RESP     = 25'h0000008,
        S_CLR_FLAG = 25'h0000010,
        S_INIT     = 25'h0000020,
        S_LOOP     = 25'h0000040,
        S_P_TOP    = 25'h0000080,
        S_P_LAST   = 25'h0000100,
        S_SD_L     = 25'h0000200,
        S_SD_R     = 25'h0000400,
        S_SD_CMP   = 25'h0000800,
        S_SU_CHK   = 25'h0001000,
        S_SU_CMP   = 25'h0002000,
        S_N_CHK    = 25'h0004000,
        S_N_FLAG   = 25'h0008000,
        S_N_S1     = 25'h0010000,
        S_N_S2     = 25'h0020000,
        S_N_S3     = 25'h0040000,
        S_N_G      = 25'h0080000,
        S_N_DK     = 25'h0100000,
        S_N_PUSH   = 25'h0200000,
        S_NEXT     = 25'h0400000,
        S_TR_RD    = 25'h0800000,
        S_TR_CHK   = 25'h1000000
    } t_state;

    t_state            r_state;
    logic [DIM_W-1:0]  r_w;
    logic [DIM_W-1:0]  r_h;
    t_in_item          r_item;
    t_out_item         r_out;
    logic              r_out_valid;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_size;
    logic [CELL_W-1:0] r_start;
    logic [CELL_W-1:0] r_node;
    logic [G_W-1:0]    r_node_g;
    logic [G_W-1:0]    r_ng;
    logic [CELL_W-1:0] r_i;
    t_heap_ent         r_elem;
    t_heap_ent         r_lft;
    logic [1:0]        r_ox;
    logic [1:0]        r_oy;
    logic [COL_W-1:0]  r_nx;
    logic [ROW_W-1:0]  r_ny;
    logic [1:0]        r_flag;
    logic [CELL_W-1:0] r_cur;
    logic [CNT_W-1:0]  r_k;

    // cell tables
    logic              r_solid_mem [CELLS];
    logic [1:0]        r_flag_mem  [CELLS];
    logic [CELL_W-1:0] r_pred_mem  [CELLS];
    logic [G_W-1:0]    r_g_mem     [CELLS];
    t_heap_ent         r_heap_mem  [CELLS];
    logic [CELL_W-1:0] r_hpos_mem  [CELLS];
    logic [CELL_W-1:0] r_path_mem  [CELLS];

    logic              r_solid_rd;
    logic [1:0]        r_flag_rd;
    logic [CELL_W-1:0] r_pred_rd;
    logic [G_W-1:0]    r_g_rd;
    t_heap_ent         r_heap_rd;
    logic [CELL_W-1:0] r_hpos_rd;
    logic [CELL_W-1:0] r_path_rd;

    logic solid_we, flag_we, pred_we, g_we, heap_we, hpos_we, path_we;
    logic [CELL_W-1:0] solid_wa, solid_ra, flag_wa, flag_ra, pred_wa, pred_ra;
    logic [CELL_W-1:0] g_wa, g_ra, heap_wa, heap_ra, hpos_wa, hpos_ra, path_wa, path_ra;
    logic              solid_wd;
    logic [1:0]        flag_wd;
    logic [CELL_W-1:0] pred_wd, hpos_wd, path_wd;
    logic [G_W-1:0]    g_wd;
    t_heap_ent         heap_wd;

    logic [DIM_W-1:0]  w_eff;
    logic [DIM_W-1:0]  h_eff;
    logic              in_acc;
    logic              start_ok;
    logic [COL_W-1:0]  node_x;
    logic [ROW_W-1:0]  node_y;
    logic [DIM_W-1:0]  xp;
    logic [DIM_W-1:0]  yp;
    logic [COL_W-1:0]  nx_c;
    logic [ROW_W-1:0]  ny_c;
    logic              nb_ok;
    logic [CELL_W-1:0] nb;
    logic [G_W-1:0]    ng;
    logic [G_W-1:0]    oct;
    logic [F_W-1:0]    new_f;
    logic [CNT_W-1:0]  lchild;
    logic [CNT_W-1:0]  rchild;
    logic [CELL_W-1:0] parent;
    t_heap_ent         m_ent;
    logic [CELL_W-1:0] m_idx;
    logic              m_move;
    logic              rd_ok;
    logic [CNT_W-1:0]  rd_addr;
    logic [CELL_W-1:0] goal_cell;

    gaps_octile u_octile (
        .i_clk  (i_clk),
        .i_x    (r_nx),
        .i_y    (r_ny),
        .i_gx   (r_item.goal_x),
        .i_gy   (r_item.goal_y),
        .o_dist (oct)
    );

    assign w_eff = (r_w == '0) ? DIM_W'(1) : ((r_w > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : r_w);
    assign h_eff = (r_h == '0) ? DIM_W'(1) : ((r_h > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : r_h);

    assign o_in_ready  = (r_state == S_IDLE) && !r_out_valid;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign in_acc      = i_in_valid && o_in_ready;

    assign start_ok = (DIM_W'(i_in_data.tile_x) < w_eff) && (DIM_W'(i_in_data.tile_y) < h_eff) &&
                      (DIM_W'(i_in_data.goal_x) < w_eff) && (DIM_W'(i_in_data.goal_y) < h_eff);

    assign node_x = r_node[COL_W-1:0];
    assign node_y = r_node[CELL_W-1:COL_W];
    assign xp     = DIM_W'(node_x) + DIM_W'(r_ox);
    assign yp     = DIM_W'(node_y) + DIM_W'(r_oy);
    assign nx_c   = COL_W'(xp - DIM_W'(1));
    assign ny_c   = ROW_W'(yp - DIM_W'(1));
    assign nb_ok  = (xp != '0) && (xp <= w_eff) && (yp != '0) && (yp <= h_eff) &&
                    !(r_ox == 2'd1 && r_oy == 2'd1);
    assign nb     = {r_ny, r_nx};
    assign ng     = r_node_g + ((r_ox != 2'd1 && r_oy != 2'd1) ? G_W'(STEP_DIAG)
                                                               : G_W'(STEP_STRAIGHT));
    assign new_f  = F_W'(r_ng) + F_W'(oct);

    assign lchild = {r_i, 1'b1};
    assign rchild = lchild + CNT_W'(1);
    assign parent = (r_i - CELL_W'(1)) >> 1;

    assign goal_cell = {r_item.goal_y, r_item.goal_x};
    assign rd_ok     = (r_item.action == ACT_READ) && ({1'b0, r_item.path_index} < r_count);
    // path is stored end first
    assign rd_addr   = r_count - CNT_W'(1) - {1'b0, r_item.path_index};

    always_comb begin
        m_ent  = r_elem;
        m_idx  = r_i;
        m_move = 1'b0;
        if (r_lft < m_ent) begin
            m_ent  = r_lft;
            m_idx  = lchild[CELL_W-1:0];
            m_move = 1'b1;
        end
        if ((rchild < r_size) && (r_heap_rd < m_ent)) begin
            m_ent  = r_heap_rd;
            m_idx  = rchild[CELL_W-1:0];
            m_move = 1'b1;
        end
    end

    // memory port control
    always_comb begin
        solid_we = 1'b0; solid_wa = '0; solid_wd = 1'b0; solid_ra = '0;
        flag_we  = 1'b0; flag_wa  = '0; flag_wd  = '0;   flag_ra  = '0;
        pred_we  = 1'b0; pred_wa  = '0; pred_wd  = '0;   pred_ra  = '0;
        g_we     = 1'b0; g_wa     = '0; g_wd     = '0;   g_ra     = '0;
        heap_we  = 1'b0; heap_wa  = '0; heap_wd  = '0;   heap_ra  = '0;
        hpos_we  = 1'b0; hpos_wa  = '0; hpos_wd  = '0;   hpos_ra  = '0;
        path_we  = 1'b0; path_wa  = '0; path_wd  = '0;   path_ra  = '0;
        unique case (r_state)
            S_CLR_MAP: begin
                solid_we = 1'b1;
                solid_wa = r_cnt[CELL_W-1:0];
            end
            S_IDLE: begin
                if (in_acc && i_in_data.action == ACT_WRITE) begin
                    solid_we = 1'b1;
                    solid_wa = {i_in_data.tile_y, i_in_data.tile_x};
                    solid_wd = i_in_data.solid_bit;
                end
            end
            S_RD_ISS: path_ra = rd_addr[CELL_W-1:0];
            S_RESP: ;
            S_CLR_FLAG: begin
                flag_we = 1'b1;
                flag_wa = r_cnt[CELL_W-1:0];
            end
            S_INIT: begin
                flag_we = 1'b1; flag_wa = r_start; flag_wd = FLAG_OPEN;
                g_we    = 1'b1; g_wa    = r_start;
            end
            S_LOOP: heap_ra = '0;
            S_P_TOP: begin
                flag_we = 1'b1; flag_wa = r_heap_rd.loc; flag_wd = FLAG_CLOSED;
                g_ra    = r_heap_rd.loc;
                heap_ra = CELL_W'(r_size - CNT_W'(1));
            end
            S_P_LAST: ;
            S_SD_L: begin
                if (lchild < r_size) begin
                    heap_ra = lchild[CELL_W-1:0];
                end else begin
                    heap_we = 1'b1; heap_wa = r_i; heap_wd = r_elem;
                    hpos_we = 1'b1; hpos_wa = r_elem.loc; hpos_wd = r_i;
                end
            end
            S_SD_R: heap_ra = rchild[CELL_W-1:0];
            S_SD_CMP: begin
                heap_we = 1'b1; heap_wa = r_i; heap_wd = m_ent;
                hpos_we = 1'b1; hpos_wa = m_ent.loc; hpos_wd = r_i;
            end
            S_SU_CHK: begin
                if (r_i == '0) begin
                    heap_we = 1'b1; heap_wa = r_i; heap_wd = r_elem;
                    hpos_we = 1'b1; hpos_wa = r_elem.loc; hpos_wd = r_i;
                end else begin
                    heap_ra = parent;
                end
            end
            S_SU_CMP: begin
                heap_we = 1'b1; heap_wa = r_i; hpos_we = 1'b1; hpos_wd = r_i;
                if (r_elem < r_heap_rd) begin
                    heap_wd = r_heap_rd; hpos_wa = r_heap_rd.loc;
                end else begin
                    heap_wd = r_elem; hpos_wa = r_elem.loc;
                end
            end
            S_N_CHK:  flag_ra  = {ny_c, nx_c};
            S_N_FLAG: solid_ra = {r_ny, node_x};
            S_N_S1:   solid_ra = {node_y, r_nx};
            S_N_S2:   solid_ra = nb;
            S_N_S3: begin
                if (!r_solid_rd) begin
                    if (r_flag[0]) begin
                        g_ra = nb;
                    end else begin
                        flag_we = 1'b1; flag_wa = nb; flag_wd = FLAG_OPEN;
                        pred_we = 1'b1; pred_wa = nb; pred_wd = r_node;
                        g_we    = 1'b1; g_wa    = nb; g_wd    = ng;
                    end
                end
            end
            S_N_G: begin
                hpos_ra = nb;
                if (r_g_rd > r_ng) begin
                    pred_we = 1'b1; pred_wa = nb; pred_wd = r_node;
                    g_we    = 1'b1; g_wa    = nb; g_wd    = r_ng;
                end
            end
            S_N_DK: ;
            S_N_PUSH: ;
            S_NEXT: ;
            S_TR_RD: begin
                path_we = 1'b1; path_wa = r_k[CELL_W-1:0]; path_wd = r_cur;
                flag_ra = r_cur;
                pred_ra = r_cur;
            end
            S_TR_CHK: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (solid_we) r_solid_mem[solid_wa] <= solid_wd;
        if (flag_we)  r_flag_mem[flag_wa]   <= flag_wd;
        if (pred_we)  r_pred_mem[pred_wa]   <= pred_wd;
        if (g_we)     r_g_mem[g_wa]         <= g_wd;
        if (heap_we)  r_heap_mem[heap_wa]   <= heap_wd;
        if (hpos_we)  r_hpos_mem[hpos_wa]   <= hpos_wd;
        if (path_we)  r_path_mem[path_wa]   <= path_wd;
        r_solid_rd <= r_solid_mem[solid_ra];
        r_flag_rd  <= r_flag_mem[flag_ra];
        r_pred_rd  <= r_pred_mem[pred_ra];
        r_g_rd     <= r_g_mem[g_ra];
        r_heap_rd  <= r_heap_mem[heap_ra];
        r_hpos_rd  <= r_hpos_mem[hpos_ra];
        r_path_rd  <= r_path_mem[path_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR_MAP;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_w         <= DIM_W'(MAX_COLS);
            r_h         <= DIM_W'(MAX_ROWS);
            r_count     <= '0;
            r_size      <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index[0])
                    REG_GRID_W: r_w <= i_cfg_data;
                    REG_GRID_H: r_h <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLR_MAP: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(CELLS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_item  <= i_in_data;
                        r_nx    <= i_in_data.tile_x;
                        r_ny    <= i_in_data.tile_y;
                        r_start <= {i_in_data.tile_y, i_in_data.tile_x};
                        r_cnt   <= '0;
                        unique case (i_in_data.action)
                            ACT_SEARCH: begin
                                if (start_ok) begin
                                    r_state <= S_CLR_FLAG;
                                end else begin
                                    r_count <= '0;
                                    r_state <= S_RESP;
                                end
                            end
                            ACT_READ: r_state <= S_RD_ISS;
                            ACT_WRITE, ACT_NOP: r_state <= S_RESP;
                            default: r_state <= S_RESP;
                        endcase
                    end
                end
                S_RD_ISS: r_state <= S_RESP;
                S_RESP: begin
                    r_out.path_length <= r_count;
                    r_out.entry_valid <= rd_ok;
                    r_out.pixel_x     <= rd_ok ? PIX_W'(r_path_rd[COL_W-1:0]) * PIX_W'(TILE_PIXELS)
                                                 + PIX_W'(TILE_PIXELS / 2) : '0;
                    r_out.pixel_y     <= rd_ok ? PIX_W'(r_path_rd[CELL_W-1:COL_W])
                                                 * PIX_W'(TILE_PIXELS)
                                                 + PIX_W'(TILE_PIXELS / 2) : '0;
                    r_out_valid       <= 1'b1;
                    r_state           <= S_IDLE;
                end
                S_CLR_FLAG: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(CELLS - 1)) r_state <= S_INIT;
                end
                S_INIT: begin
                    r_elem  <= '{f: F_W'(oct), loc: r_start};
                    r_i     <= '0;
                    r_size  <= CNT_W'(1);
                    r_ox    <= 2'd2;
                    r_oy    <= 2'd2;
                    r_state <= S_SU_CHK;
                end
                S_LOOP: begin
                    if (r_size == '0) begin
                        r_cur   <= goal_cell;
                        r_k     <= '0;
                        r_state <= S_TR_RD;
                    end else begin
                        r_state <= S_P_TOP;
                    end
                end
                S_P_TOP: begin
                    r_node  <= r_heap_rd.loc;
                    r_size  <= r_size - CNT_W'(1);
                    r_state <= S_P_LAST;
                end
                S_P_LAST: begin
                    r_node_g <= r_g_rd;
                    r_elem   <= r_heap_rd;
                    r_i      <= '0;
                    r_ox     <= 2'd0;
                    r_oy     <= 2'd0;
                    r_state  <= (r_size != '0) ? S_SD_L : S_N_CHK;
                end
                S_SD_L:   r_state <= (lchild < r_size) ? S_SD_R : S_N_CHK;
                S_SD_R: begin
                    r_lft   <= r_heap_rd;
                    r_state <= S_SD_CMP;
                end
                S_SD_CMP: begin
                    if (m_move) begin
                        r_i     <= m_idx;
                        r_state <= S_SD_L;
                    end else begin
                        r_state <= S_N_CHK;
                    end
                end
                S_SU_CHK: r_state <= (r_i == '0) ? S_NEXT : S_SU_CMP;
                S_SU_CMP: begin
                    if (r_elem < r_heap_rd) begin
                        r_i     <= parent;
                        r_state <= S_SU_CHK;
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_N_CHK: begin
                    r_nx    <= nx_c;
                    r_ny    <= ny_c;
                    r_state <= nb_ok ? S_N_FLAG : S_NEXT;
                end
                S_N_FLAG: begin
                    r_flag  <= r_flag_rd;
                    r_state <= r_flag_rd[1] ? S_NEXT : S_N_S1;
                end
                S_N_S1: r_state <= r_solid_rd ? S_NEXT : S_N_S2;
                S_N_S2: r_state <= r_solid_rd ? S_NEXT : S_N_S3;
                S_N_S3: begin
                    r_ng <= ng;
                    if (r_solid_rd)   r_state <= S_NEXT;
                    else if (r_flag[0]) r_state <= S_N_G;
                    else              r_state <= S_N_PUSH;
                end
                S_N_G: r_state <= (r_g_rd > r_ng) ? S_N_DK : S_NEXT;
                S_N_DK: begin
                    r_i     <= r_hpos_rd;
                    r_elem  <= '{f: new_f, loc: nb};
                    r_state <= S_SU_CHK;
                end
                S_N_PUSH: begin
                    r_i     <= r_size[CELL_W-1:0];
                    r_size  <= r_size + CNT_W'(1);
                    r_elem  <= '{f: new_f, loc: nb};
                    r_state <= S_SU_CHK;
                end
                S_NEXT: begin
                    if (r_ox == 2'd2) begin
                        if (r_oy == 2'd2) begin
                            r_state <= S_LOOP;
                        end else begin
                            r_oy    <= r_oy + 2'd1;
                            r_ox    <= 2'd0;
                            r_state <= S_N_CHK;
                        end
                    end else begin
                        r_ox    <= r_ox + 2'd1;
                        r_state <= S_N_CHK;
                    end
                end
                S_TR_RD: begin
                    r_k     <= r_k + CNT_W'(1);
                    r_state <= S_TR_CHK;
                end
                S_TR_CHK: begin
                    // the start cell is the only opened cell without a predecessor
                    if (r_flag_rd != 2'b00 && r_cur != r_start && r_k < CNT_W'(CELLS)) begin
                        r_cur   <= r_pred_rd;
                        r_state <= S_TR_RD;
                    end else begin
                        r_count <= r_k;
                        r_state <= S_RESP;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[hw/rtl/gaps_port_check.sv]
`include "assert_macros.svh"

module gaps_port_check import gaps_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_data
);

    // no new item while a result still waits
    `CHK_HOLDS(a_no_accept_while_full, i_clk, i_rst_n, (i_in_valid && i_in_ready) |-> !i_out_valid)
    `CHK_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    `CHK_HOLDS(a_blank_pixels, i_clk, i_rst_n, (i_out_valid && !i_out_data.entry_valid) |-> (i_out_data.pixel_x == '0 && i_out_data.pixel_y == '0))
    `CHK_HOLDS(a_entry_needs_path, i_clk, i_rst_n, (i_out_valid && i_out_data.entry_valid) |-> (i_out_data.path_length != '0))
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data))

endmodule

bind grid_astar_path_search_top gaps_port_check u_port_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);

[bench/grid_astar_path_search_top_tb.sv]
`timescale 1ns / 1ps

module grid_astar_path_search_top_tb;
    import gaps_pkg::*;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    t_in_item         i_in_data = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_out_item        o_out_data;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [0:0]       i_cfg_index = '0;
    logic [DIM_W-1:0] i_cfg_data = '0;

    grid_astar_path_search_top dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // shadow of the block: map, search tables, stored route
    bit          solid_tiles[CELLS];
    bit [1:0]    cell_flags[CELLS];
    int unsigned came_from[CELLS];
    bit          came_from_ok[CELLS];
    int unsigned g_cost[CELLS];
    int unsigned h_cost[CELLS];
    int unsigned open_list[CELLS];
    int unsigned open_slot[CELLS];
    int unsigned open_size;
    int unsigned route[CELLS];
    int unsigned back_trace[CELLS];
    int unsigned route_len;
    int unsigned cols_reg = 64;
    int unsigned rows_reg = 64;

    t_in_item  pending_items[$];
    t_out_item expected_results[$];
    int        mismatches;
    int        results_seen;
    int        searches_run;
    int        valid_reads;
    int        burst_left;
    int        gap_left;
    int        ready_run;

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned maxv);
        if (v < 1) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic int unsigned octile_dist(int unsigned x, int unsigned y,
                                                int unsigned gx, int unsigned gy);
        int unsigned dx, dy, lo;
        dx = (x > gx) ? x - gx : gx - x;
        dy = (y > gy) ? y - gy : gy - y;
        lo = (dx < dy) ? dx : dy;
        return STEP_DIAG * lo + STEP_STRAIGHT * (dx + dy - 2 * lo);
    endfunction

    // lower f first, then lower cell index
    function automatic bit ranks_ahead(int unsigned a, int unsigned b);
        int unsigned fa, fb;
        fa = g_cost[a] + h_cost[a];
        fb = g_cost[b] + h_cost[b];
        if (fa != fb) return fa < fb;
        return a < b;
    endfunction

    function automatic void swap_slots(int unsigned i, int unsigned j);
        int unsigned t;
        t = open_list[i];
        open_list[i] = open_list[j];
        open_list[j] = t;
        open_slot[open_list[i]] = i;
        open_slot[open_list[j]] = j;
    endfunction

    function automatic void bubble_up(int unsigned i);
        int unsigned p;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (!ranks_ahead(open_list[i], open_list[p])) break;
            swap_slots(i, p);
            i = p;
        end
    endfunction

    function automatic void bubble_down(int unsigned i);
        int unsigned l, r, m;
        forever begin
            l = 2 * i + 1;
            r = l + 1;
            m = i;
            if (l < open_size && ranks_ahead(open_list[l], open_list[m])) m = l;
            if (r < open_size && ranks_ahead(open_list[r], open_list[m])) m = r;
            if (m == i) break;
            swap_slots(i, m);
            i = m;
        end
    endfunction

    function automatic void run_astar(int unsigned sx, int unsigned sy,
                                      int unsigned gx, int unsigned gy);
        int unsigned w, h, node, x, y, nb, ng, cur, k;
        w = clamp_dim(cols_reg, MAX_COLS);
        h = clamp_dim(rows_reg, MAX_ROWS);
        if (sx >= w || sy >= h || gx >= w || gy >= h) begin
            route_len = 0;
            return;
        end
        foreach (cell_flags[i]) begin
            cell_flags[i] = '0;
            came_from_ok[i] = 1'b0;
        end
        node = sy * MAX_COLS + sx;
        g_cost[node] = 0;
        h_cost[node] = octile_dist(sx, sy, gx, gy);
        cell_flags[node] = FLAG_OPEN;
        open_list[0] = node;
        open_slot[node] = 0;
        open_size = 1;
        while (open_size > 0) begin
            node = open_list[0];
            open_size--;
            if (open_size > 0) begin
                open_list[0] = open_list[open_size];
                open_slot[open_list[0]] = 0;
                bubble_down(0);
            end
            x = node % MAX_COLS;
            y = node / MAX_COLS;
            cell_flags[node] = FLAG_CLOSED;
            for (int yy = int'(y) - 1; yy <= int'(y) + 1; yy++) begin
                if (yy < 0 || yy >= int'(h)) continue;
                for (int xx = int'(x) - 1; xx <= int'(x) + 1; xx++) begin
                    if (xx < 0 || xx >= int'(w)) continue;
                    nb = yy * MAX_COLS + xx;
                    if (cell_flags[nb] & FLAG_CLOSED) continue;
                    // both corner tiles must be clear
                    if (solid_tiles[yy * MAX_COLS + x] || solid_tiles[y * MAX_COLS + xx])
                        continue;
                    if (solid_tiles[nb]) continue;
                    ng = g_cost[node] + ((xx != x && yy != y) ? STEP_DIAG : STEP_STRAIGHT);
                    if (!(cell_flags[nb] & FLAG_OPEN)) begin
                        cell_flags[nb] = FLAG_OPEN;
                        came_from[nb] = node;
                        came_from_ok[nb] = 1'b1;
                        h_cost[nb] = octile_dist(xx, yy, gx, gy);
                        g_cost[nb] = ng;
                        open_list[open_size] = nb;
                        open_slot[nb] = open_size;
                        open_size++;
                        bubble_up(open_size - 1);
                    end else if (g_cost[nb] > ng) begin
                        came_from[nb] = node;
                        came_from_ok[nb] = 1'b1;
                        g_cost[nb] = ng;
                        bubble_up(open_slot[nb]);
                    end
                end
            end
        end
        cur = gy * MAX_COLS + gx;
        k = 0;
        while (k < CELLS) begin
            back_trace[k++] = cur;
            if (!came_from_ok[cur]) break;
            cur = came_from[cur] % CELLS;
        end
        for (int unsigned i = 0; i < k; i++) route[i] = back_trace[k - 1 - i];
        route_len = k;
    endfunction

    function automatic t_out_item predict_result(t_in_item it);
        t_out_item r;
        int unsigned c;
        r = '0;
        case (it.action)
            ACT_WRITE: solid_tiles[it.tile_y * MAX_COLS + it.tile_x] = it.solid_bit;
            ACT_SEARCH: begin
                run_astar(it.tile_x, it.tile_y, it.goal_x, it.goal_y);
                searches_run++;
            end
            ACT_READ: begin
                if (it.path_index < route_len) begin
                    c = route[it.path_index];
                    r.pixel_x = 11'((c % MAX_COLS) * TILE_PIXELS + TILE_PIXELS / 2);
                    r.pixel_y = 11'((c / MAX_COLS) * TILE_PIXELS + TILE_PIXELS / 2);
                    r.entry_valid = 1'b1;
                    valid_reads++;
                end
            end
            default: ;
        endcase
        r.path_length = 13'(route_len);
        return r;
    endfunction

    // sender: bursts of transfers separated by random gaps
    always @(posedge i_clk) begin
        if (i_in_valid && o_in_ready)
            expected_results = {expected_results, predict_result(i_in_data)};
        if (!i_in_valid || o_in_ready) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                i_in_data <= pending_items.pop_front();
                i_in_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 10);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: alternating runs of ready and stall
    always @(posedge i_clk) begin
        if (ready_run > 0) begin
            ready_run--;
        end else begin
            i_out_ready <= ~i_out_ready;
            ready_run = i_out_ready ? $urandom_range(0, 6) : $urandom_range(0, 20);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_out_data);
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.path_length !== want.path_length ||
                    o_out_data.pixel_x !== want.pixel_x ||
                    o_out_data.pixel_y !== want.pixel_y ||
                    o_out_data.entry_valid !== want.entry_valid) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d mismatch: expected %p got %p",
                                 results_seen, want, o_out_data);
                end
            end
        end
    end

    function automatic void add_item(t_action act, int unsigned tx, int unsigned ty,
                                     int unsigned gx, int unsigned gy,
                                     bit sb, int unsigned idx);
        t_in_item it;
        it.action = act;
        it.tile_x = 6'(tx);
        it.tile_y = 6'(ty);
        it.goal_x = 6'(gx);
        it.goal_y = 6'(gy);
        it.solid_bit = sb;
        it.path_index = 12'(idx);
        pending_items = {pending_items, it};
    endfunction

    task automatic write_reg(logic [0:0] idx, int unsigned value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= DIM_W'(value);
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        if (idx == REG_GRID_W) cols_reg = value & 'h7f;
        else rows_reg = value & 'h7f;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        int unsigned w, h;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full-size grid, goal behind a small wall
        write_reg(REG_GRID_W, 64);
        write_reg(REG_GRID_H, 64);
        add_item(ACT_READ, 0, 0, 0, 0, 0, 0);
        add_item(ACT_WRITE, 63, 63, 0, 0, 1, 0);
        add_item(ACT_WRITE, 63, 63, 0, 0, 0, 4095);
        add_item(ACT_WRITE, 62, 62, 0, 0, 1, 0);
        add_item(ACT_WRITE, 63, 62, 0, 0, 1, 0);
        add_item(ACT_SEARCH, 0, 0, 63, 63, 0, 0);
        add_item(ACT_READ, 0, 0, 0, 0, 0, 0);
        add_item(ACT_READ, 0, 0, 0, 0, 0, 63);
        add_item(ACT_READ, 0, 0, 0, 0, 0, 64);
        add_item(ACT_READ, 63, 63, 63, 63, 1, 4095);
        add_item(ACT_NOP, 63, 63, 63, 63, 1, 4095);
        drain();

        // zero size counts as one tile
        write_reg(REG_GRID_W, 0);
        write_reg(REG_GRID_H, 0);
        add_item(ACT_SEARCH, 0, 0, 0, 0, 0, 0);
        add_item(ACT_READ, 0, 0, 0, 0, 0, 0);
        add_item(ACT_SEARCH, 1, 0, 0, 0, 0, 0);
        add_item(ACT_READ, 0, 0, 0, 0, 0, 0);
        drain();

        // oversized width clamps; solid start still expands
        write_reg(REG_GRID_W, 127);
        write_reg(REG_GRID_H, 3);
        add_item(ACT_WRITE, 5, 1, 0, 0, 1, 0);
        add_item(ACT_SEARCH, 5, 1, 60, 2, 0, 0);
        add_item(ACT_READ, 0, 0, 0, 0, 0, 0);
        add_item(ACT_READ, 0, 0, 0, 0, 0, 54);
        add_item(ACT_SEARCH, 0, 0, 0, 3, 0, 0);
        drain();

        // wall leaves the goal unreachable, then an opened tile gives a route around blocked diagonals
        write_reg(REG_GRID_W, 3);
        write_reg(REG_GRID_H, 2);
        add_item(ACT_WRITE, 1, 0, 0, 0, 1, 0);
        add_item(ACT_WRITE, 1, 1, 0, 0, 1, 0);
        add_item(ACT_SEARCH, 0, 0, 2, 0, 0, 0);
        add_item(ACT_READ, 0, 0, 0, 0, 0, 0);
        add_item(ACT_READ, 0, 0, 0, 0, 0, 1);
        add_item(ACT_WRITE, 1, 1, 0, 0, 0, 0);
        add_item(ACT_SEARCH, 0, 0, 2, 0, 0, 0);
        add_item(ACT_READ, 0, 0, 0, 0, 0, 2);
        drain();

        // random phases: small maps, tile writes, one or two searches, then reads along the route
        for (int ph = 0; ph < 8; ph++) begin
            w = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(2, 10);
            h = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(2, 10);
            write_reg(REG_GRID_W, w);
            write_reg(REG_GRID_H, h);
            if (w == 0) w = 1;
            if (h == 0) h = 1;
            for (int i = 0; i < 4; i++)
                add_item(ACT_WRITE, $urandom_range(0, w), $urandom_range(0, h),
                         $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 2) == 0, $urandom_range(0, 4095));
            if ($urandom_range(0, 4) == 0)
                add_item(ACT_SEARCH, $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 63), $urandom_range(0, 63), 1, 0);
            add_item(ACT_SEARCH, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
                     $urandom_range(0, w - 1), $urandom_range(0, h - 1),
                     $urandom_range(0, 1), $urandom_range(0, 4095));
            for (int i = 0; i < 6; i++)
                add_item(ACT_READ, $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 1), $urandom_range(0, w + h + 1));
            add_item(($urandom_range(0, 1) == 0) ? ACT_NOP : ACT_READ,
                     $urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 1), $urandom_range(0, 4095));
            drain();
        end

        repeat (50) @(posedge i_clk);
        $display("covered %0d results, %0d searches, %0d in-route reads",
                 results_seen, searches_run, valid_reads);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     expected_results.size());
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("timeout");
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/gaps_pkg.sv
hw/rtl/gaps_octile.sv
hw/rtl/grid_astar_path_search_top.sv
hw/rtl/gaps_port_check.sv
bench/grid_astar_path_search_top_tb.sv
